[sv/tsl_pkg.sv]
// ----------------------------------------------------------------------------
// tsl_pkg: shared types and constants of the triangle strip to list unit
// Vertex and triangle types, configuration, status structs and code values.
// ----------------------------------------------------------------------------
package tsl_pkg;

  localparam int unsigned IdxW      = 16;
  localparam int unsigned CornerW   = 2;
  localparam int unsigned CountW    = 2;
  localparam int unsigned CornerCnt = 3;
  localparam int unsigned AddrW     = 3;
  localparam int unsigned DataW     = 32;

  localparam logic [IdxW-1:0]    RestartValueReset = 16'hFFFF;
  localparam logic [CountW-1:0]  CountSat          = 2'd3;
  localparam logic [CornerW-1:0] FirstCorner       = 2'd0;
  localparam logic [CornerW-1:0] LastCorner        = 2'd2;

  // register index taken from paddr[2]
  localparam logic RegRestartEnable = 1'b0;
  localparam logic RegRestartValue  = 1'b1;

  typedef struct packed {
    logic [IdxW-1:0] position;
    logic [IdxW-1:0] color;
    logic [IdxW-1:0] normal;
    logic [IdxW-1:0] uv;
    logic [IdxW-1:0] uv2;
  } vertex_t;

  typedef vertex_t [CornerCnt-1:0] triangle_t;

  typedef struct packed {
    logic            restart_enable;
    logic [IdxW-1:0] restart_value;
  } cfg_t;

  typedef struct packed {
    logic      load;
    triangle_t corners;
  } load_t;

  typedef struct packed {
    logic busy;
    logic can_load;
    logic last_xfer;
  } queue_status_t;

  typedef struct packed {
    logic [CountW-1:0] seen_count;
    logic              emit;
  } core_status_t;

endpackage

[sv/tsl_vertex_if.sv]
// ----------------------------------------------------------------------------
// tsl_vertex_if: strip vertex channel
// Valid/ready channel carrying one strip vertex per transfer.
// ----------------------------------------------------------------------------
interface tsl_vertex_if;

  logic                     valid;
  logic                     ready;
  logic                     strip_start;
  logic [tsl_pkg::IdxW-1:0] pos_idx;
  logic [tsl_pkg::IdxW-1:0] col_idx;
  logic [tsl_pkg::IdxW-1:0] nrm_idx;
  logic [tsl_pkg::IdxW-1:0] tex_idx;
  logic [tsl_pkg::IdxW-1:0] tex2_idx;

  modport source (
    output valid, strip_start, pos_idx, col_idx, nrm_idx, tex_idx, tex2_idx,
    input  ready
  );

  modport sink (
    input  valid, strip_start, pos_idx, col_idx, nrm_idx, tex_idx, tex2_idx,
    output ready
  );

endinterface

[sv/tsl_corner_if.sv]
// ----------------------------------------------------------------------------
// tsl_corner_if: triangle corner channel
// Valid/ready channel carrying one triangle corner per transfer.
// ----------------------------------------------------------------------------
interface tsl_corner_if;

  logic                        valid;
  logic                        ready;
  logic [tsl_pkg::IdxW-1:0]    corner_position;
  logic [tsl_pkg::IdxW-1:0]    corner_color;
  logic [tsl_pkg::IdxW-1:0]    corner_normal;
  logic [tsl_pkg::IdxW-1:0]    corner_uv;
  logic [tsl_pkg::IdxW-1:0]    corner_uv2;
  logic [tsl_pkg::CornerW-1:0] corner_number;
  logic                        last_corner;

  modport source (
    output valid, corner_position, corner_color, corner_normal, corner_uv,
           corner_uv2, corner_number, last_corner,
    input  ready
  );

  modport sink (
    input  valid, corner_position, corner_color, corner_normal, corner_uv,
           corner_uv2, corner_number, last_corner,
    output ready
  );

endinterface

[sv/tsl_cfg_regs.sv]
// ----------------------------------------------------------------------------
// tsl_cfg_regs: APB configuration registers
// Restart enable at byte 0, restart value at byte 4; pready is tied high.
// ----------------------------------------------------------------------------
module tsl_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tsl_pkg::AddrW-1:0]   paddr,
  input  logic [tsl_pkg::DataW-1:0]   pwdata,
  output logic [tsl_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output tsl_pkg::cfg_t               cfg_o
);
  import tsl_pkg::*;

  logic            en_q, en_d;
  logic [IdxW-1:0] rv_q, rv_d;
  logic            wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_comb begin
    en_d = en_q;
    rv_d = rv_q;
    if (wr) begin
      case (paddr[2])
        RegRestartEnable: en_d = pwdata[0];
        RegRestartValue:  rv_d = pwdata[IdxW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
      rv_q <= RestartValueReset;
    end else begin
      en_q <= en_d;
      rv_q <= rv_d;
    end
  end

  always_comb begin
    case (paddr[2])
      RegRestartEnable: prdata = {{(DataW-1){1'b0}}, en_q};
      RegRestartValue:  prdata = {{(DataW-IdxW){1'b0}}, rv_q};
      default:          prdata = '0;
    endcase
  end

  assign cfg_o.restart_enable = en_q;
  assign cfg_o.restart_value  = rv_q;

endmodule

[sv/tsl_strip_core.sv]
// ----------------------------------------------------------------------------
// tsl_strip_core: strip history and triangle assembly
// Keeps the two previous vertices and the count, flags degenerate vertices.
// ----------------------------------------------------------------------------
module tsl_strip_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  tsl_vertex_if.sink             vertex_i,
  input  tsl_pkg::cfg_t          cfg_i,
  input  tsl_pkg::queue_status_t qstat_i,
  output tsl_pkg::load_t         load_o,
  output tsl_pkg::core_status_t  cstat_o
);
  import tsl_pkg::*;

  vertex_t           older_q, older_d, prev_q, prev_d;
  vertex_t           older_eff, prev_eff, cur;
  logic [CountW-1:0] cnt_q, cnt_d, cnt_eff, cnt_inc;
  logic              odd_q, odd_d, odd_eff, odd_inc;
  logic              accept, degenerate, emit, restart;

  assign vertex_i.ready = qstat_i.can_load;
  assign accept         = vertex_i.valid && vertex_i.ready;

  assign cur.position = vertex_i.pos_idx;
  assign cur.color    = vertex_i.col_idx;
  assign cur.normal   = vertex_i.nrm_idx;
  assign cur.uv       = vertex_i.tex_idx;
  assign cur.uv2      = vertex_i.tex2_idx;

  always_comb begin
    // strip start wipes history before this vertex is looked at
    older_eff = vertex_i.strip_start ? '0 : older_q;
    prev_eff  = vertex_i.strip_start ? '0 : prev_q;
    cnt_eff   = vertex_i.strip_start ? '0 : cnt_q;
    odd_eff   = vertex_i.strip_start ? 1'b0 : odd_q;

    cnt_inc = (cnt_eff == CountSat) ? cnt_eff : cnt_eff + 2'd1;
    odd_inc = ~odd_eff;

    degenerate = (cur == older_eff) || (cur == prev_eff) || (older_eff == prev_eff);
    emit       = !degenerate && (cnt_inc == CountSat);
    restart    = !degenerate && cfg_i.restart_enable &&
                 (cur.position == cfg_i.restart_value);

    older_d = older_q;
    prev_d  = prev_q;
    cnt_d   = cnt_q;
    odd_d   = odd_q;
    if (accept) begin
      older_d = prev_eff;
      prev_d  = cur;
      cnt_d   = restart ? '0 : cnt_inc;
      odd_d   = restart ? 1'b0 : odd_inc;
    end
  end

  // corner order keeps the winding constant across the strip
  always_comb begin
    load_o.load = accept && emit;
    if (odd_inc) begin
      load_o.corners[0] = cur;
      load_o.corners[1] = prev_eff;
      load_o.corners[2] = older_eff;
    end else begin
      load_o.corners[0] = older_eff;
      load_o.corners[1] = prev_eff;
      load_o.corners[2] = cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q <= '0;
      prev_q  <= '0;
      cnt_q   <= '0;
      odd_q   <= 1'b0;
    end else begin
      older_q <= older_d;
      prev_q  <= prev_d;
      cnt_q   <= cnt_d;
      odd_q   <= odd_d;
    end
  end

  assign cstat_o.seen_count = cnt_q;
  assign cstat_o.emit       = emit;

endmodule

[sv/tsl_corner_queue.sv]
// ----------------------------------------------------------------------------
// tsl_corner_queue: triangle result register and corner serializer
// Holds one triangle and sends its three corners in order.
// ----------------------------------------------------------------------------
module tsl_corner_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tsl_pkg::load_t         load_i,
  tsl_corner_if.source           corner_o,
  output tsl_pkg::queue_status_t qstat_o
);
  import tsl_pkg::*;

  triangle_t          tri_q, tri_d;
  logic               busy_q, busy_d;
  logic [CornerW-1:0] idx_q, idx_d;
  logic               xfer, last_xfer;
  vertex_t            sel;

  assign xfer      = corner_o.valid && corner_o.ready;
  assign last_xfer = xfer && (idx_q == LastCorner);

  always_comb begin
    tri_d  = tri_q;
    busy_d = busy_q;
    idx_d  = idx_q;
    if (xfer) begin
      if (last_xfer) begin
        busy_d = 1'b0;
        idx_d  = FirstCorner;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
    if (load_i.load) begin
      tri_d  = load_i.corners;
      busy_d = 1'b1;
      idx_d  = FirstCorner;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= FirstCorner;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tri_q <= tri_d;
  end

  always_comb begin
    case (idx_q)
      2'd0:    sel = tri_q[0];
      2'd1:    sel = tri_q[1];
      2'd2:    sel = tri_q[2];
      default: sel = tri_q[2];
    endcase
  end

  assign corner_o.valid           = busy_q;
  assign corner_o.corner_position = sel.position;
  assign corner_o.corner_color    = sel.color;
  assign corner_o.corner_normal   = sel.normal;
  assign corner_o.corner_uv       = sel.uv;
  assign corner_o.corner_uv2      = sel.uv2;
  assign corner_o.corner_number   = idx_q;
  assign corner_o.last_corner     = (idx_q == LastCorner);

  assign qstat_o.busy      = busy_q;
  assign qstat_o.can_load  = !busy_q || last_xfer;
  assign qstat_o.last_xfer = last_xfer;

endmodule

[sv/triangle_strip_to_list_unit.sv]
// ----------------------------------------------------------------------------
// triangle_strip_to_list_unit: triangle strip to triangle list converter
// Turns strip vertices into triangle corners, with optional strip restart.
// ----------------------------------------------------------------------------
// Usage:
//   vertex_i takes one strip vertex per transfer (strip start mark and five
//   attribute indices). corner_o gives triangle corners, three per triangle,
//   numbered 0..2 with last_corner set on corner 2.
//   Degenerate vertices and the first two vertices of a strip give no
//   corners but still advance the history.
//   Corner 0 shows in the cycle after the vertex transfer; corners 1 and 2
//   follow back to back when the receiver keeps ready high. A vertex that
//   produces a triangle holds the corner register until its three corners
//   have transferred on the single corner channel; vertices that produce
//   nothing go at one per cycle only while no triangle is held. The next
//   vertex is taken in the cycle the last corner of the held triangle
//   transfers. Reset clears the vertex history, the count, the corner
//   queue's busy flag and the configuration (restart off, restart value 0xFFFF).
//   When the receiver stalls, the held corner waits and vertex_i.ready drops
//   until the triangle has drained.
//   APB: byte 0 restart_enable, byte 4 restart_value; write only while idle.
// ----------------------------------------------------------------------------
module triangle_strip_to_list_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  tsl_vertex_if.sink                vertex_i,
  tsl_corner_if.source              corner_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [tsl_pkg::AddrW-1:0] paddr,
  input  logic [tsl_pkg::DataW-1:0] pwdata,
  output logic [tsl_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import tsl_pkg::*;

  cfg_t          cfg;
  load_t         load;
  queue_status_t qstat;
  core_status_t  cstat;

  // Configuration registers
  tsl_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Vertex history, degenerate check and corner ordering
  tsl_strip_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vertex_i (vertex_i),
    .cfg_i    (cfg),
    .qstat_i  (qstat),
    .load_o   (load),
    .cstat_o  (cstat)
  );

  // Hold the triangle and advance one corner per transfer
  tsl_corner_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .corner_o (corner_o),
    .qstat_o  (qstat)
  );

  // A new triangle never overwrites one that still has corners to send
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load.load |-> (!qstat.busy || qstat.last_xfer))
    else $error("triangle loaded over undelivered corners");

  // Drained triangle with no new load leaves the output empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (qstat.last_xfer && !load.load) |=> !corner_o.valid)
    else $error("corner output valid after triangle drained");

  // A triangle transfer starts at corner 0
  a_first_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load.load |=> (corner_o.valid && corner_o.corner_number == FirstCorner))
    else $error("triangle does not start at corner 0");

  // The first vertex of a strip is always degenerate and counts as one
  a_strip_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vertex_i.valid && vertex_i.ready && vertex_i.strip_start) |->
      (!cstat.emit ##1 cstat.seen_count == 2'd1))
    else $error("strip start vertex miscounted");

endmodule

[tb/sv/triangle_strip_to_list_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_strip_to_list_unit_tb: self-checking bench of the strip converter
// Feeds strip vertices through a valid/ready driver, predicts the triangle
// corners in a software copy of the strip history, and checks every corner
// the monitor collects. Runs under several restart settings and idle patterns.
// ----------------------------------------------------------------------------
module triangle_strip_to_list_unit_tb;

  import tsl_pkg::*;

  localparam int unsigned AttrCnt      = $bits(vertex_t) / IdxW;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned LongHold     = 150;
  localparam int unsigned MaxReports   = 20;

  typedef struct packed {
    logic    start;
    vertex_t attr;
  } strip_vertex_t;

  typedef struct packed {
    vertex_t            attr;
    logic [CornerW-1:0] number;
    logic               last;
  } corner_t;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  tsl_vertex_if vertex_bus ();
  tsl_corner_if corner_bus ();

  triangle_strip_to_list_unit i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vertex_i (vertex_bus),
    .corner_o (corner_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Stimulus and expectation stores
  strip_vertex_t pending_vertices[$];
  corner_t       expected_corners[$];
  strip_vertex_t offered;

  // Strip history as the block should hold it
  vertex_t           kept_older    = '0;
  vertex_t           kept_previous = '0;
  logic [CountW-1:0] seen_count    = '0;
  logic              count_odd     = 1'b0;

  // Register copies, written together with the block's registers
  logic            restart_en_shadow  = 1'b0;
  logic [IdxW-1:0] restart_val_shadow = RestartValueReset;

  // Last two generated vertices, reused to provoke degenerate vertices
  vertex_t last_generated[2] = '{default: '0};

  int unsigned send_idle_pct    = 0;
  int unsigned recv_idle_pct    = 0;
  bit          hold_request     = 1'b0;
  int unsigned hold_left        = 0;
  int unsigned vertices_queued  = 0;
  int unsigned vertices_accepted = 0;
  int unsigned silent_vertices  = 0;
  int unsigned corners_checked  = 0;
  int unsigned error_count      = 0;
  int unsigned cycle_count      = 0;

  // --------------------------------------------------------------------------
  // Corner prediction: advance the strip history by one vertex and queue the
  // three corners of the triangle it closes, if any.
  // --------------------------------------------------------------------------
  function automatic void predict_corners(input logic start, input vertex_t cur);
    vertex_t corners[CornerCnt];
    logic    degenerate;
    corner_t c;
    // a strip start wipes the history before the vertex is looked at
    if (start) begin
      kept_older    = '0;
      kept_previous = '0;
      seen_count    = '0;
      count_odd     = 1'b0;
    end
    if (seen_count < CountSat) begin
      seen_count++;
    end
    count_odd = ~count_odd;
    // equal to a kept vertex, or the kept pair collapsed: no triangle
    degenerate = (cur == kept_older) || (cur == kept_previous) ||
                 (kept_older == kept_previous);
    if (!degenerate) begin
      if (seen_count == CountSat) begin
        // flip the corner order on even counts to keep the winding
        corners[0] = count_odd ? cur : kept_older;
        corners[1] = kept_previous;
        corners[2] = count_odd ? kept_older : cur;
        for (int k = 0; k < CornerCnt; k++) begin
          c.attr   = corners[k];
          c.number = CornerW'(k);
          c.last   = (c.number == LastCorner);
          expected_corners.insert(expected_corners.size(), c);
        end
      end else begin
        silent_vertices++;
      end
      // restart clears the count after any triangle, history stays
      if (restart_en_shadow && cur.position == restart_val_shadow) begin
        seen_count = '0;
        count_odd  = 1'b0;
      end
    end else begin
      silent_vertices++;
    end
    kept_older    = kept_previous;
    kept_previous = cur;
  endfunction

  function automatic vertex_t make_vertex(input logic [IdxW-1:0] p, c, n, u, u2);
    vertex_t v;
    v.position = p;
    v.color    = c;
    v.normal   = n;
    v.uv       = u;
    v.uv2      = u2;
    return v;
  endfunction

  // Random vertex: mostly fresh indices with extremes mixed in, sometimes a
  // repeat of a recent vertex or a restart position.
  function automatic vertex_t random_vertex();
    logic [AttrCnt-1:0][IdxW-1:0] fields;
    vertex_t                      v;
    int unsigned                  pick;
    foreach (fields[i]) begin
      case ($urandom_range(7))
        0:       fields[i] = '0;
        1:       fields[i] = '1;
        default: fields[i] = IdxW'($urandom);
      endcase
    end
    v    = fields;
    pick = $urandom_range(99);
    if (pick < 10) begin
      v = last_generated[0];
    end else if (pick < 18) begin
      v = last_generated[1];
    end else if (pick < 28) begin
      v.position = restart_val_shadow;
    end else if (pick < 31) begin
      v = '0;
    end
    last_generated[1] = last_generated[0];
    last_generated[0] = v;
    return v;
  endfunction

  task automatic queue_vertex(input logic start, input vertex_t v);
    strip_vertex_t item;
    item.start = start;
    item.attr  = v;
    pending_vertices.insert(pending_vertices.size(), item);
    vertices_queued++;
  endtask

  // Well-formed strips of random length; a few stray strip starts as noise.
  task automatic queue_random_strips(input int unsigned count);
    int unsigned left;
    int unsigned strip_len;
    left = count;
    while (left > 0) begin
      strip_len = $urandom_range(12, 2);
      for (int unsigned k = 0; k < strip_len && left > 0; k++) begin
        queue_vertex((k == 0) || ($urandom_range(99) < 3), random_vertex());
        left--;
      end
    end
  endtask

  // Hold until every vertex went in and every corner came out, then let the
  // pipeline settle, since a vertex with no corners may still be in flight.
  task automatic wait_idle();
    while (vertices_accepted != vertices_queued || expected_corners.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // APB write with random upper bits, followed by a read-back of the register.
  task automatic set_register(input logic reg_index, input logic [IdxW-1:0] value);
    logic [DataW-1:0] mask;
    logic [DataW-1:0] readback;
    mask = (reg_index == RegRestartEnable) ? DataW'(1) : DataW'({IdxW{1'b1}});
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_index, 2'b00};
    pwdata  <= ($urandom & ~mask) | (DataW'(value) & mask);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (reg_index == RegRestartEnable) begin
      restart_en_shadow = value[0];
    end else begin
      restart_val_shadow = value;
    end
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    psel     <= 1'b0;
    penable  <= 1'b0;
    if ((readback & mask) !== (DataW'(value) & mask)) begin
      error_count++;
      $display("%0t: register %0d read-back, expected %h actual %h",
               $time, reg_index, DataW'(value) & mask, readback & mask);
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: timeout after %0d cycles, %0d corners still expected",
             cycle_count, expected_corners.size());
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Vertex driver: predict on each transfer, then offer the next vertex when
  // the slot is free and the sender is not idling this cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_bus.valid <= 1'b0;
    end else begin
      if (vertex_bus.valid && vertex_bus.ready) begin
        predict_corners(offered.start, offered.attr);
        vertices_accepted++;
      end
      if (!vertex_bus.valid || vertex_bus.ready) begin
        if (pending_vertices.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = pending_vertices.pop_front();
          vertex_bus.valid       <= 1'b1;
          vertex_bus.strip_start <= offered.start;
          vertex_bus.pos_idx     <= offered.attr.position;
          vertex_bus.col_idx     <= offered.attr.color;
          vertex_bus.nrm_idx     <= offered.attr.normal;
          vertex_bus.tex_idx     <= offered.attr.uv;
          vertex_bus.tex2_idx    <= offered.attr.uv2;
        end else begin
          vertex_bus.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Corner monitor: check each transfer against the oldest expected corner,
  // and drive ready with random stalls or a long counted hold-off.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    corner_t got;
    corner_t want;
    if (!rst_ni) begin
      corner_bus.ready <= 1'b0;
    end else begin
      if (corner_bus.valid && corner_bus.ready) begin
        got.attr.position = corner_bus.corner_position;
        got.attr.color    = corner_bus.corner_color;
        got.attr.normal   = corner_bus.corner_normal;
        got.attr.uv       = corner_bus.corner_uv;
        got.attr.uv2      = corner_bus.corner_uv2;
        got.number        = corner_bus.corner_number;
        got.last          = corner_bus.last_corner;
        if (expected_corners.size() == 0) begin
          error_count++;
          if (error_count <= MaxReports) begin
            $display("%0t: unexpected corner, expected none, actual %h", $time, got);
          end
        end else begin
          want = expected_corners.pop_front();
          corners_checked++;
          if (got !== want) begin
            error_count++;
            if (error_count <= MaxReports) begin
              $display("%0t: corner mismatch (pos/col/nrm/uv/uv2 #num last)", $time);
              $display("  expected %h/%h/%h/%h/%h #%0d %0b", want.attr.position,
                       want.attr.color, want.attr.normal, want.attr.uv,
                       want.attr.uv2, want.number, want.last);
              $display("  actual   %h/%h/%h/%h/%h #%0d %0b", got.attr.position,
                       got.attr.color, got.attr.normal, got.attr.uv,
                       got.attr.uv2, got.number, got.last);
            end
          end
        end
      end
      // start a long hold-off on request, so the block backs up into its input
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LongHold;
      end
      if (hold_left != 0) begin
        hold_left--;
        corner_bus.ready <= 1'b0;
      end else begin
        corner_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    // drive every input to a known value from time zero
    rst_ni                 = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    vertex_bus.valid       = 1'b0;
    vertex_bus.strip_start = 1'b0;
    vertex_bus.pos_idx     = '0;
    vertex_bus.col_idx     = '0;
    vertex_bus.nrm_idx     = '0;
    vertex_bus.tex_idx     = '0;
    vertex_bus.tex2_idx    = '0;
    corner_bus.ready       = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed strips: restart on at the all-ones position.
    // Idle pattern: sender rarely, receiver mostly.
    send_idle_pct = 6;
    recv_idle_pct = 76;
    set_register(RegRestartEnable, 16'd1);
    set_register(RegRestartValue, 16'hFFFF);
    queue_vertex(1'b1, make_vertex(1, 2, 3, 4, 5));       // first vertex, kept pair zero
    queue_vertex(1'b0, make_vertex(6, 7, 8, 9, 10));      // second vertex, no triangle
    queue_vertex(1'b0, make_vertex(11, 12, 13, 14, 15));  // odd count: new first
    queue_vertex(1'b0, make_vertex(16, 17, 18, 19, 20));  // even count: older first
    queue_vertex(1'b0, make_vertex(21, 22, 23, 24, 25));  // count saturated
    queue_vertex(1'b0, make_vertex(21, 22, 23, 24, 25));  // repeat of previous
    queue_vertex(1'b0, make_vertex(30, 31, 32, 33, 34));  // kept pair equal
    queue_vertex(1'b0, make_vertex(21, 22, 23, 24, 25));  // repeat of older
    queue_vertex(1'b0, '1);                                // triangle, then restart
    queue_vertex(1'b0, '0);                                // all zero, count restarts
    queue_vertex(1'b0, make_vertex(16'hFFFF, 0, 16'hFFFF, 0, 16'hFFFF)); // restart, no tri
    queue_vertex(1'b0, make_vertex(0, 16'hFFFF, 0, 16'hFFFF, 0));
    queue_vertex(1'b0, make_vertex(9, 9, 9, 9, 9));
    queue_vertex(1'b0, make_vertex(9, 9, 9, 9, 10));      // differs in one index only
    queue_vertex(1'b0, make_vertex(9, 9, 9, 9, 10));      // repeat of previous
    queue_vertex(1'b0, make_vertex(16'hFFFF, 5, 5, 5, 5)); // degenerate, restart skipped
    queue_vertex(1'b0, make_vertex(3, 3, 3, 3, 3));
    queue_vertex(1'b0, make_vertex(4, 4, 4, 4, 4));
    queue_vertex(1'b1, make_vertex(7, 7, 7, 7, 7));        // strip start mid strip
    queue_vertex(1'b0, make_vertex(8, 8, 8, 8, 8));
    queue_vertex(1'b0, make_vertex(10, 10, 10, 10, 10));
    queue_vertex(1'b1, '0);                                // start on the zero vertex
    queue_vertex(1'b0, '0);
    wait_idle();

    // Random strips, restart on at a small value
    set_register(RegRestartValue, 16'h0007);
    queue_random_strips(145);
    wait_idle();

    // Restart off at value zero; swap the idle pattern. Drain once midway so
    // the sender pauses until every triangle has come out.
    send_idle_pct = 76;
    recv_idle_pct = 6;
    set_register(RegRestartEnable, 16'd0);
    set_register(RegRestartValue, 16'h0000);
    queue_random_strips(70);
    wait_idle();
    queue_random_strips(75);
    wait_idle();

    // Restart on at value zero, no idling; start with a long receiver hold
    // while the sender keeps offering, so the input backs up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_register(RegRestartEnable, 16'd1);
    hold_request = 1'b1;
    queue_random_strips(145);
    wait_idle();

    $display("tb: %0d vertices sent, %0d corners checked, %0d vertices without a triangle",
             vertices_accepted, corners_checked, silent_vertices);
    $display("tb: restart on and off at 0x0000, 0x0007 and 0xFFFF, long hold and drain");
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d errors", error_count);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
